@@ hdl/ultrasonic_ranger_serial_report_macros.svh @@
// Assertion macros used by the ranger checker.
`ifndef ULTRASONIC_RANGER_SERIAL_REPORT_MACROS_SVH
`define ULTRASONIC_RANGER_SERIAL_REPORT_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define USR_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ranger check failed (same cycle)");

// Next-cycle implication, sampled on clock, off during reset.
`define USR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ranger check failed (next cycle)");

`endif

@@ hdl/usr_pkg.sv @@
// Types, constants and helpers shared by the ultrasonic ranger modules.
`timescale 1ns / 1ps
package usr_pkg;

   localparam int MAX_DIGITS_DEF = 5;
   localparam int BCD_DIGITS     = 5;
   localparam int FRAME_BITS     = 12;
   localparam int CSR_AW         = 5;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;

   localparam logic [9:0]  TRIGGER_TICKS_RST = 10'd30;
   localparam logic [7:0]  TICKS_PER_CM_RST  = 8'd58;
   localparam logic [17:0] WINDOW_TICKS_RST  = 18'd50000;
   localparam logic [15:0] MAX_RANGE_RST     = 16'd400;
   localparam logic [15:0] BIT_TICKS_RST     = 16'd105;

   typedef enum logic [2:0] {
      REG_TRIGGER_TICKS = 3'd0,
      REG_TICKS_PER_CM  = 3'd1,
      REG_WINDOW_TICKS  = 3'd2,
      REG_MAX_RANGE     = 3'd3,
      REG_BIT_TICKS     = 3'd4
   } csr_reg_type;

   typedef enum logic [1:0] {
      PH_TRIGGER = 2'd0,
      PH_WINDOW  = 2'd1,
      PH_SEND    = 2'd2
   } phase_type;

   typedef struct packed {
      logic [9:0]  trigger_ticks;
      logic [7:0]  ticks_per_cm;
      logic [17:0] window_ticks;
      logic [15:0] max_range_cm;
      logic [15:0] bit_ticks;
   } cfg_type;

   typedef logic [4*BCD_DIGITS-1:0] bcd_type;

   // control from the phase sequencer to the echo measurement
   typedef struct packed {
      logic clear_capture;
      logic take;
   } meas_ctl_type;

   // limited capture, binary and BCD
   typedef struct packed {
      logic [15:0] range;
      bcd_type     bcd;
   } meas_res_type;

   function automatic bcd_type bcd_inc(input bcd_type v);
      bcd_type    r;
      logic       carry;
      logic [3:0] d;
      r     = v;
      carry = 1'b1;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         d = v[4*i +: 4];
         if (carry) begin
            if (d == 4'd9) begin
               r[4*i +: 4] = 4'd0;
            end else begin
               r[4*i +: 4] = d + 4'd1;
               carry       = 1'b0;
            end
         end
      end
      return r;
   endfunction

endpackage

@@ hdl/usr_echo.sv @@
// Echo pulse measurement: cm prescaler, binary and BCD count, capture and range limit.
`timescale 1ns / 1ps
module usr_echo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 echo_level,
   input  logic [7:0]           ticks_per_cm,
   input  logic [15:0]          max_range_cm,
   input  usr_pkg::meas_ctl_type ctl,
   output usr_pkg::meas_res_type res
);
   import usr_pkg::*;

   logic        echo_prev_ff, echo_prev_in;
   logic [7:0]  pre_ff, pre_in;
   logic [15:0] count_ff, count_in;
   bcd_type     count_bcd_ff, count_bcd_in;
   logic [15:0] capt_ff, capt_in;
   bcd_type     capt_bcd_ff, capt_bcd_in;

   logic [15:0] capt;
   bcd_type     capt_bcd;
   logic [8:0]  pre_sum;
   logic        rise, fall;
   logic [15:0] lim;
   bcd_type     lim_bcd;

   always_comb begin
      capt     = ctl.clear_capture ? 16'd0 : capt_ff;
      capt_bcd = ctl.clear_capture ? '0 : capt_bcd_ff;
      rise     = echo_level & ~echo_prev_ff;
      fall     = ~echo_level & echo_prev_ff;
      pre_sum  = {1'b0, pre_ff} + 9'd1;
      pre_in       = pre_ff;
      count_in     = count_ff;
      count_bcd_in = count_bcd_ff;
      if (rise) begin
         pre_in       = 8'd0;
         count_in     = 16'd0;
         count_bcd_in = '0;
      end else begin
         if (fall) begin
            // capture takes the count before this tick's step
            capt     = count_ff;
            capt_bcd = count_bcd_ff;
         end
         if (pre_sum >= {1'b0, ticks_per_cm}) begin
            pre_in       = 8'd0;
            count_in     = count_ff + 16'd1;
            count_bcd_in = (count_ff == 16'hFFFF) ? '0 : bcd_inc(count_bcd_ff);
         end else begin
            pre_in = pre_sum[7:0];
         end
      end
      echo_prev_in = echo_level;

      if (capt > max_range_cm) begin
         lim     = 16'd0;
         lim_bcd = '0;
      end else begin
         lim     = capt;
         lim_bcd = capt_bcd;
      end
      capt_in     = ctl.take ? lim : capt;
      capt_bcd_in = ctl.take ? lim_bcd : capt_bcd;
      res.range   = lim;
      res.bcd     = lim_bcd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_prev_ff <= 1'b0;
         pre_ff       <= 8'd0;
         count_ff     <= 16'd0;
         count_bcd_ff <= '0;
         capt_ff      <= 16'd0;
         capt_bcd_ff  <= '0;
      end else if (enable) begin
         echo_prev_ff <= echo_prev_in;
         pre_ff       <= pre_in;
         count_ff     <= count_in;
         count_bcd_ff <= count_bcd_in;
         capt_ff      <= capt_in;
         capt_bcd_ff  <= capt_bcd_in;
      end
   end

endmodule

@@ hdl/usr_ctrl.sv @@
// Phase sequencer and serial transmitter of the decimal report.
`timescale 1ns / 1ps
module usr_ctrl #(
   parameter int MaxDigits = usr_pkg::MAX_DIGITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  usr_pkg::cfg_type      cfg,
   input  usr_pkg::meas_res_type res,
   output usr_pkg::meas_ctl_type ctl,
   output logic                  trigger_level,
   output logic                  serial_level,
   output logic [15:0]           range_cm,
   output logic                  range_valid
);
   import usr_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [17:0] timer_ff, timer_in;
   logic [15:0] bit_timer_ff, bit_timer_in;
   logic [3:0]  bit_index_ff, bit_index_in;
   logic [7:0]  tx_shift_ff, tx_shift_in;
   logic [2:0]  char_index_ff, char_index_in;
   logic [2:0]  digit_count_ff, digit_count_in;
   bcd_type     digits_ff, digits_in;
   logic        line_ff, line_in;
   logic [15:0] report_ff, report_in;

   logic [18:0] timer_sum;
   logic [16:0] bt_sum;
   logic [3:0]  ch_sum;
   logic [2:0]  pos;
   logic [3:0]  nib;
   logic [7:0]  cur_char;
   logic [2:0]  sig_count;

   // control to the echo side depends on registers only
   assign timer_sum         = {1'b0, timer_ff} + 19'd1;
   assign ctl.clear_capture = (phase_ff == PH_TRIGGER) && (timer_ff == 18'd0);
   assign ctl.take          = (phase_ff == PH_WINDOW) &&
                              (timer_sum >= {1'b0, cfg.window_ticks});

   // character at char_index: digits MSB first, then CR, then LF
   always_comb begin
      pos = digit_count_ff - 3'd1 - char_index_ff;
      nib = 4'd0;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (pos == 3'(i)) nib = digits_ff[4*i +: 4];
      end
      if (char_index_ff < digit_count_ff) cur_char = CHAR_ZERO | {4'h0, nib};
      else if (char_index_ff == digit_count_ff) cur_char = CHAR_CR;
      else cur_char = CHAR_LF;
   end

   // significant digits of the new result, at least one, capped
   always_comb begin
      sig_count = 3'd1;
      for (int i = 1; i < BCD_DIGITS; i++) begin
         if (res.bcd[4*i +: 4] != 4'd0) sig_count = 3'(i + 1);
      end
      if (sig_count > 3'(MaxDigits)) sig_count = 3'(MaxDigits);
   end

   always_comb begin
      phase_in       = phase_ff;
      timer_in       = timer_ff;
      bit_timer_in   = bit_timer_ff;
      bit_index_in   = bit_index_ff;
      tx_shift_in    = tx_shift_ff;
      char_index_in  = char_index_ff;
      digit_count_in = digit_count_ff;
      digits_in      = digits_ff;
      line_in        = line_ff;
      report_in      = report_ff;
      trigger_level  = 1'b0;
      range_valid    = 1'b0;
      bt_sum         = {1'b0, bit_timer_ff} + 17'd1;
      ch_sum         = {1'b0, char_index_ff} + 4'd1;

      unique case (phase_ff)
         PH_TRIGGER: begin
            trigger_level = 1'b1;
            timer_in      = timer_sum[17:0];
            if (timer_sum >= 19'(cfg.trigger_ticks)) begin
               phase_in = PH_WINDOW;
               timer_in = 18'd0;
            end
         end
         PH_WINDOW: begin
            timer_in = timer_sum[17:0];
            if (ctl.take) begin
               report_in      = res.range;
               range_valid    = 1'b1;
               digits_in      = res.bcd;
               digit_count_in = sig_count;
               phase_in       = PH_SEND;
               timer_in       = 18'd0;
               char_index_in  = 3'd0;
               bit_index_in   = 4'd0;
               bit_timer_in   = 16'd0;
            end
         end
         PH_SEND: begin
            if (bit_timer_ff == 16'd0) begin
               if (bit_index_ff == 4'd0) begin
                  tx_shift_in = cur_char;
                  line_in     = 1'b0;
               end else begin
                  line_in     = tx_shift_ff[0];
                  tx_shift_in = {1'b1, tx_shift_ff[7:1]};
               end
               bit_index_in = bit_index_ff + 4'd1;
            end
            if (bt_sum >= {1'b0, cfg.bit_ticks}) begin
               bit_timer_in = 16'd0;
               if (bit_index_in >= 4'(FRAME_BITS)) begin
                  bit_index_in = 4'd0;
                  if (ch_sum >= {1'b0, digit_count_ff} + 4'd2) begin
                     char_index_in = 3'd0;
                     phase_in      = PH_TRIGGER;
                     timer_in      = 18'd0;
                     line_in       = 1'b1;
                  end else begin
                     char_index_in = ch_sum[2:0];
                  end
               end
            end else begin
               bit_timer_in = bt_sum[15:0];
            end
         end
         default: begin
            phase_in = PH_TRIGGER;
            timer_in = 18'd0;
         end
      endcase

      serial_level = line_in;
      range_cm     = report_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_TRIGGER;
         timer_ff       <= 18'd0;
         bit_timer_ff   <= 16'd0;
         bit_index_ff   <= 4'd0;
         tx_shift_ff    <= 8'hFF;
         char_index_ff  <= 3'd0;
         digit_count_ff <= 3'd0;
         line_ff        <= 1'b1;
         report_ff      <= 16'd0;
      end else if (enable) begin
         phase_ff       <= phase_in;
         timer_ff       <= timer_in;
         bit_timer_ff   <= bit_timer_in;
         bit_index_ff   <= bit_index_in;
         tx_shift_ff    <= tx_shift_in;
         char_index_ff  <= char_index_in;
         digit_count_ff <= digit_count_in;
         line_ff        <= line_in;
         report_ff      <= report_in;
      end
   end

   // digit store: written at each completion before any read
   always_ff @(posedge clock) begin
      if (enable) digits_ff <= digits_in;
   end

endmodule

@@ hdl/ultrasonic_ranger_serial_report.sv @@
// Top level of the ultrasonic ranger with serial decimal report.
// An accepted request's result appears on rsp_* in the cycle after it is accepted.
// Throughput: one request per cycle unless the sink stalls a held result; each
//   request is one microsecond tick; counters, BCD step and serial shifter all advance on it.
// Reset: synchronous, active high; registers return to their documented
//   values, except the result data and the digit store, and the result register empties.
`timescale 1ns / 1ps
module ultrasonic_ranger_serial_report #(
   parameter int MaxDigits = usr_pkg::MAX_DIGITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [0] echo_level, [7:1] zero
   // result channel
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [0] trigger_level, [1] serial_level, [17:2] range_cm, [18] range_valid, [23:19] zero
   output logic [23:0]               rsp_tdata,
   // configuration port
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [usr_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);
   import usr_pkg::*;

   cfg_type      cfg_ff;
   logic         csr_wr;
   csr_reg_type  csr_sel;

   logic         accept;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [23:0]  rsp_data_ff;

   meas_ctl_type ctl;
   meas_res_type res;
   logic         trig_n, serial_n, valid_n;
   logic [15:0]  range_n;

   // ---------------------------------------------------------------
   // Configuration registers. Zero in a timing register behaves as one
   // by way of the >= compares downstream, so no fixup is needed here.
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_sel    = csr_reg_type'(csr_paddr[CSR_AW-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_ticks <= TRIGGER_TICKS_RST;
         cfg_ff.ticks_per_cm  <= TICKS_PER_CM_RST;
         cfg_ff.window_ticks  <= WINDOW_TICKS_RST;
         cfg_ff.max_range_cm  <= MAX_RANGE_RST;
         cfg_ff.bit_ticks     <= BIT_TICKS_RST;
      end else if (csr_wr) begin
         unique case (csr_sel)
            REG_TRIGGER_TICKS: cfg_ff.trigger_ticks <= csr_pwdata[9:0];
            REG_TICKS_PER_CM:  cfg_ff.ticks_per_cm  <= csr_pwdata[7:0];
            REG_WINDOW_TICKS:  cfg_ff.window_ticks  <= csr_pwdata[17:0];
            REG_MAX_RANGE:     cfg_ff.max_range_cm  <= csr_pwdata[15:0];
            REG_BIT_TICKS:     cfg_ff.bit_ticks     <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_TRIGGER_TICKS: csr_prdata = {22'd0, cfg_ff.trigger_ticks};
         REG_TICKS_PER_CM:  csr_prdata = {24'd0, cfg_ff.ticks_per_cm};
         REG_WINDOW_TICKS:  csr_prdata = {14'd0, cfg_ff.window_ticks};
         REG_MAX_RANGE:     csr_prdata = {16'd0, cfg_ff.max_range_cm};
         REG_BIT_TICKS:     csr_prdata = {16'd0, cfg_ff.bit_ticks};
         default:           csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------
   // Handshake: the result register frees up in the same cycle it is
   // drained, so a request is taken every cycle unless the sink stalls
   // with a result still held.
   // ---------------------------------------------------------------
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;

   // echo measurement: prescaler, count (binary + BCD), capture, limit
   usr_echo u_echo (
      .clock        (clock),
      .reset        (reset),
      .enable       (accept),
      .echo_level   (req_tdata[0]),
      .ticks_per_cm (cfg_ff.ticks_per_cm),
      .max_range_cm (cfg_ff.max_range_cm),
      .ctl          (ctl),
      .res          (res)
   );

   // phase sequencer and UART-style transmitter
   usr_ctrl #(
      .MaxDigits (MaxDigits)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .enable        (accept),
      .cfg           (cfg_ff),
      .res           (res),
      .ctl           (ctl),
      .trigger_level (trig_n),
      .serial_level  (serial_n),
      .range_cm      (range_n),
      .range_valid   (valid_n)
   );

   // result register
   always_comb begin
      if (accept) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_data_ff <= {5'd0, valid_n, range_n, serial_n, trig_n};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ hdl/usr_checker.sv @@
// Port-level checker for the ranger top level, with its bind.
`timescale 1ns / 1ps
`include "ultrasonic_ranger_serial_report_macros.svh"
module usr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   logic req_acc;
   assign req_acc = req_tvalid & req_tready & (req_tdata[0] | ~req_tdata[0]);

   // stalled result holds
   `USR_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // every accepted request yields a result in the next cycle
   `USR_ASSERT_NEXT(a_rsp_follows, req_acc, rsp_tvalid)
   // backpressure only while a result is held
   `USR_ASSERT_NOW(a_ready_free, !req_tready, rsp_tvalid)
   // completion never falls in the trigger phase
   `USR_ASSERT_NOW(a_valid_no_trig, rsp_tvalid && rsp_tdata[18], !rsp_tdata[0])
   // serial line idles high while triggering
   `USR_ASSERT_NOW(a_trig_line_idle, rsp_tvalid && rsp_tdata[0], rsp_tdata[1])

endmodule

bind ultrasonic_ranger_serial_report usr_checker u_usr_checker (.*);
